// File: design/akf_pkg.sv
// shared types, codes and saturation helpers for the angle/rate kalman filter
// used by angle_rate_kalman_filter; no dependencies
package akf_pkg;

   typedef struct packed {
      logic signed [24:0] angle_meas;
      logic signed [27:0] rate_meas;
   } req_type;

   typedef struct packed {
      logic signed [31:0] angle_est;
      logic signed [31:0] rate_est;
   } rsp_type;

   localparam logic [2:0] CSR_TIME_STEP   = 3'd0;
   localparam logic [2:0] CSR_ANGLE_NOISE = 3'd1;
   localparam logic [2:0] CSR_BIAS_NOISE  = 3'd2;
   localparam logic [2:0] CSR_MEAS_NOISE  = 3'd3;

   // one entry per multiply or divide of a filter step, in issue order
   typedef enum logic [3:0] {
      OP_PRED = 4'd0,
      OP_P00  = 4'd1,
      OP_P01  = 4'd2,
      OP_K0   = 4'd3,
      OP_K1   = 4'd4,
      OP_ANG  = 4'd5,
      OP_BIAS = 4'd6,
      OP_AA   = 4'd7,
      OP_AB   = 4'd8,
      OP_BA   = 4'd9,
      OP_BB   = 4'd10
   } op_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] fx_add(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
      return sat32(35'(a) + 35'(b));
   endfunction

   function automatic logic signed [31:0] fx_sub(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
      return sat32(35'(a) - 35'(b));
   endfunction

endpackage

// File: design/akf_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle, with
// round-half-up rescale and 32-bit saturation
module akf_mul #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic               done,
   output logic signed [31:0] result
);
   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [33:0] hi_ff, hi_in;
   logic [32:0]        lo_ff, lo_in;
   logic signed [32:0] a_ff, a_in;
   logic signed [31:0] res_ff, res_in;
   logic signed [33:0] t;
   logic signed [66:0] prod, rnd, shf;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      res_in  = res_ff;
      t       = hi_ff;
      prod    = $signed({hi_ff, lo_ff});
      rnd     = prod + (67'sd1 <<< (FRAC_BITS - 1));
      shf     = rnd >>> FRAC_BITS;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         hi_in   = '0;
         lo_in   = op_b;
         a_in    = op_a;
      end else if (busy_ff) begin
         // the sign bit of the multiplier carries negative weight
         if (lo_ff[0]) begin
            t = (cnt_ff == 6'd32) ? hi_ff - 34'(a_ff) : hi_ff + 34'(a_ff);
         end
         hi_in  = {t[33], t[33:1]};
         lo_in  = {t[0], lo_ff[32:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd32) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         done_in = 1'b1;
         if (shf > 67'sh7FFF_FFFF) begin
            res_in = 32'sh7FFF_FFFF;
         end else if (shf < -67'sh8000_0000) begin
            res_in = 32'sh8000_0000;
         end else begin
            res_in = shf[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

   a_fin_after_busy: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> $past(busy_ff) && !busy_ff)
      else $error("multiplier finished without running");
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(fin_ff))
      else $error("multiplier done without rescale");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !fin_ff)
      else $error("multiplier busy during rescale");
endmodule

// File: design/akf_div.sv
// restoring divider for gains: (num * 2^FRAC_BITS) / den, one quotient bit
// per cycle, truncated toward zero and saturated
module akf_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);
   localparam int QW = 32 + FRAC_BITS;
   localparam int CW = $clog2(QW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       dm_ff, dm_in;
   logic [QW-1:0]     q_ff, q_in;
   logic signed [31:0] res_ff, res_in;
   logic [32:0]       r2;
   logic              bit_q;
   logic [QW-1:0]     q_next;
   logic [31:0]       nm;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      q_in    = q_ff;
      res_in  = res_ff;
      nm      = num[31] ? 32'(-num) : num;
      r2      = {rem_ff, q_ff[QW-1]};
      bit_q   = (r2 >= {1'b0, dm_ff});
      q_next  = {q_ff[QW-2:0], bit_q};
      if (start && !busy_ff) begin
         if (den == 32'sd0) begin
            // zero denominator gives a zero gain
            res_in  = '0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = '0;
            neg_in  = num[31] ^ den[31];
            dm_in   = den[31] ? 32'(-den) : den;
            q_in    = {nm, {FRAC_BITS{1'b0}}};
         end
      end else if (busy_ff) begin
         rem_in = bit_q ? 32'(r2 - {1'b0, dm_ff}) : r2[31:0];
         q_in   = q_next;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               res_in = (q_next > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                       : $signed(q_next[31:0]);
            end else begin
               res_in = (q_next > QW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000
                        : $signed(32'(QW'(0) - q_next));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      dm_ff  <= dm_in;
      q_ff   <= q_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign quot = res_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < dm_ff)
      else $error("divider remainder out of range");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still running");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> dm_ff != 32'd0)
      else $error("divider running on zero denominator");
endmodule

// File: design/angle_rate_kalman_filter.sv
// two-state angle/gyro-bias kalman filter, top level with step sequencer
// instantiates akf_mul and akf_div; uses akf_pkg
//
// Each request beat carries one angle and one rate sample; one response beat
// returns the filtered angle and the bias-corrected rate. A step issues nine
// multiplies and two divides in turn on one bit-serial multiplier and one
// restoring divider, which skips its iterations when the denominator is zero.
// After the response is loaded the sequencer returns to idle, where the next
// request is taken. One item is in work at a time; a finished result waits
// in the response register while the next request is taken. Configuration
// writes should be made only while no item is in work.
module angle_rate_kalman_filter #(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  akf_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output akf_pkg::rsp_type rsp_data,
   input  logic            csr_we,
   input  logic [2:0]      csr_index,
   input  logic [22:0]     csr_wdata
);
   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam logic [16:0] RST_TS = 17'((ONE * 1 + 50) / 100);
   localparam logic [15:0] RST_QA = 16'((ONE * 2 + 500) / 1000);
   localparam logic [15:0] RST_QB = 16'((ONE * 35 + 5000) / 10000);
   localparam logic [22:0] RST_R  = 23'((ONE * 6 + 5) / 10);
   localparam logic signed [31:0] RST_COV = 32'(ONE);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LAUNCH = 5'b00010,
      ST_WAIT   = 5'b00100,
      ST_WRITE  = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   akf_pkg::op_type op_ff, op_in;

   logic [16:0] ts_ff;
   logic [15:0] qa_ff, qb_ff;
   logic [22:0] r_ff;

   logic signed [31:0] angle_ff, bias_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [24:0] meas_ff;
   logic signed [27:0] rate_ff;
   logic signed [31:0] pred_ff, err_ff, p00_ff, p01_ff, p10_ff, p11_ff, den_ff;
   logic signed [31:0] k0_ff, k1_ff, rout_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   akf_pkg::rsp_type   rsp_data_ff;

   logic               is_div, mul_start, div_start, mul_done, div_done;
   logic signed [32:0] mul_a, mul_b;
   logic signed [31:0] div_num, mul_res, div_res, pred_w, bias_w;
   logic signed [33:0] ts_ext;

   assign ts_ext = $signed({17'b0, ts_ff});
   assign is_div = (op_ff == akf_pkg::OP_K0) || (op_ff == akf_pkg::OP_K1);
   assign mul_start = (state_ff == ST_LAUNCH) && !is_div;
   assign div_start = (state_ff == ST_LAUNCH) && is_div;
   assign div_num = (op_ff == akf_pkg::OP_K0) ? p00_ff : p10_ff;

   always_comb begin
      mul_a = 33'(k0_ff);
      mul_b = 33'(err_ff);
      unique case (op_ff)
         akf_pkg::OP_PRED: begin
            mul_a = 33'(akf_pkg::fx_sub(34'(rate_ff), 34'(bias_ff)));
            mul_b = ts_ext[32:0];
         end
         akf_pkg::OP_P00: begin
            mul_a = 33'(akf_pkg::fx_add(34'(ab_ff), 34'(ba_ff)));
            mul_b = ts_ext[32:0];
         end
         akf_pkg::OP_P01: begin
            mul_a = 33'(bb_ff);
            mul_b = ts_ext[32:0];
         end
         akf_pkg::OP_ANG:  begin mul_a = 33'(k0_ff); mul_b = 33'(err_ff); end
         akf_pkg::OP_BIAS: begin mul_a = 33'(k1_ff); mul_b = 33'(err_ff); end
         akf_pkg::OP_AA:   begin mul_a = 33'(k0_ff); mul_b = 33'(p00_ff); end
         akf_pkg::OP_AB:   begin mul_a = 33'(k0_ff); mul_b = 33'(p01_ff); end
         akf_pkg::OP_BA:   begin mul_a = 33'(k1_ff); mul_b = 33'(p00_ff); end
         akf_pkg::OP_BB:   begin mul_a = 33'(k1_ff); mul_b = 33'(p01_ff); end
         default: begin
            mul_a = 33'(k0_ff);
            mul_b = 33'(err_ff);
         end
      endcase
   end

   akf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   akf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_res)
   );

   assign pred_w = akf_pkg::fx_add(34'(angle_ff), 34'(mul_res));
   assign bias_w = akf_pkg::fx_add(34'(bias_ff), 34'(mul_res));

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LAUNCH;
               op_in    = akf_pkg::OP_PRED;
            end
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if ((is_div && div_done) || (!is_div && mul_done)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (op_ff == akf_pkg::OP_BB) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_LAUNCH;
               op_in    = akf_pkg::op_type'(op_ff + 4'd1);
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= akf_pkg::OP_PRED;
         rsp_valid_ff <= 1'b0;
         ts_ff        <= RST_TS;
         qa_ff        <= RST_QA;
         qb_ff        <= RST_QB;
         r_ff         <= RST_R;
         angle_ff     <= '0;
         bias_ff      <= '0;
         aa_ff        <= RST_COV;
         ab_ff        <= '0;
         ba_ff        <= '0;
         bb_ff        <= RST_COV;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            priority case (csr_index)
               akf_pkg::CSR_TIME_STEP:   ts_ff <= csr_wdata[16:0];
               akf_pkg::CSR_ANGLE_NOISE: qa_ff <= csr_wdata[15:0];
               akf_pkg::CSR_BIAS_NOISE:  qb_ff <= csr_wdata[15:0];
               akf_pkg::CSR_MEAS_NOISE:  r_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_WRITE) begin
            unique case (op_ff)
               akf_pkg::OP_ANG:  angle_ff <= akf_pkg::fx_add(34'(pred_ff), 34'(mul_res));
               akf_pkg::OP_BIAS: bias_ff  <= bias_w;
               akf_pkg::OP_AA:   aa_ff <= akf_pkg::fx_sub(34'(p00_ff), 34'(mul_res));
               akf_pkg::OP_AB:   ab_ff <= akf_pkg::fx_sub(34'(p01_ff), 34'(mul_res));
               akf_pkg::OP_BA:   ba_ff <= akf_pkg::fx_sub(34'(p10_ff), 34'(mul_res));
               akf_pkg::OP_BB:   bb_ff <= akf_pkg::fx_sub(34'(p11_ff), 34'(mul_res));
               default: ;
            endcase
         end
      end
      if (state_ff == ST_IDLE && req_valid) begin
         meas_ff <= req_data.angle_meas;
         rate_ff <= req_data.rate_meas;
      end
      if (state_ff == ST_WRITE) begin
         unique case (op_ff)
            akf_pkg::OP_PRED: begin
               pred_ff <= pred_w;
               err_ff  <= akf_pkg::fx_sub(34'(meas_ff), 34'(pred_w));
            end
            akf_pkg::OP_P00: begin
               p00_ff <= akf_pkg::fx_sub(
                  34'(akf_pkg::fx_add(34'(aa_ff), $signed({18'b0, qa_ff}))),
                  34'(mul_res));
            end
            akf_pkg::OP_P01: begin
               p01_ff <= akf_pkg::fx_sub(34'(ab_ff), 34'(mul_res));
               p10_ff <= akf_pkg::fx_sub(34'(ba_ff), 34'(mul_res));
               p11_ff <= akf_pkg::fx_add(34'(bb_ff), $signed({18'b0, qb_ff}));
               den_ff <= akf_pkg::fx_add(34'(p00_ff), $signed({11'b0, r_ff}));
            end
            akf_pkg::OP_K0:   k0_ff <= div_res;
            akf_pkg::OP_K1:   k1_ff <= div_res;
            akf_pkg::OP_BIAS: rout_ff <= akf_pkg::fx_sub(34'(rate_ff), 34'(bias_w));
            default: ;
         endcase
      end
      if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff.angle_est <= angle_ff;
         rsp_data_ff.rate_est  <= rout_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");
   a_write_after_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> $past(state_ff == ST_WAIT))
      else $error("writeback without a finished unit");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_LAUNCH) && (op_ff == akf_pkg::OP_PRED))
      else $error("accepted request did not start a step");
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("both units launched together");
endmodule
